### hdl/pec_pkg.sv
// pec_pkg: shared constants of the polygon edge clipper
// default coordinate width, output vertex cap and post-emit step codes, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pec_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int MAX_OUT_VERTICES_DEF = 255;

  // step that follows once the output register has been taken
  localparam logic [1:0] POST_Y    = 2'd0;
  localparam logic [1:0] POST_E    = 2'd1;
  localparam logic [1:0] POST_DONE = 2'd2;
  localparam logic [1:0] POST_IDLE = 2'd3;

endpackage

`default_nettype wire

### hdl/polygon_edge_clipper_unit.sv
// polygon_edge_clipper_unit: one Sutherland-Hodgman clip stage against edge A -> B
// depends on pec_pkg for default parameters and post-emit step codes
//
//  channel   direction  handshake              payload
//  vertex    in         in_valid / in_ready    vertex_x, vertex_y, last_vertex
//  result    out        out_valid / out_ready  out_x, out_y, is_vertex,
//                                              end_of_polygon, vertex_count
//  config    in         write_enable           write_index, write_data
//
// one vertex request forms two cross products for each edge classified, plus
// one multiply-divide pass per magnitude bit (COORD_BITS + 1 bits) for each intersection
// coordinate, all on one shared multiplier and one serial divider
// in_ready is high only while the sequencer is idle; a stalled output holds it
// rst is synchronous and clears the sequencer, edge registers and polygon state
`timescale 1ns / 1ps
`default_nettype none

module polygon_edge_clipper_unit #(
  parameter int COORD_BITS = pec_pkg::COORD_BITS_DEF,
  parameter int MAX_OUT_VERTICES = pec_pkg::MAX_OUT_VERTICES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] vertex_x,
  input  wire logic signed [COORD_BITS-1:0] vertex_y,
  input  wire logic                         last_vertex,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic                              is_vertex,
  output logic                              end_of_polygon,
  output logic [7:0]                        vertex_count,
  input  wire logic                         write_enable,
  input  wire logic [1:0]                   write_index,
  input  wire logic [COORD_BITS-1:0]        write_data
);

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  localparam int RW = XW + 2;
  localparam int IW = $clog2(DW);
  localparam logic [7:0] CAP =
    (MAX_OUT_VERTICES < 255) ? 8'(MAX_OUT_VERTICES) : 8'd255;

  localparam logic [1:0] IDX_AX = 2'd0;
  localparam logic [1:0] IDX_AY = 2'd1;
  localparam logic [1:0] IDX_BX = 2'd2;
  localparam logic [1:0] IDX_BY = 2'd3;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M1   = 4'd1;
  localparam logic [3:0] ST_M2   = 4'd2;
  localparam logic [3:0] ST_CR   = 4'd3;
  localparam logic [3:0] ST_DEC  = 4'd4;
  localparam logic [3:0] ST_DEN  = 4'd5;
  localparam logic [3:0] ST_DIV0 = 4'd6;
  localparam logic [3:0] ST_DADD = 4'd7;
  localparam logic [3:0] ST_DSUB = 4'd8;
  localparam logic [3:0] ST_DFIN = 4'd9;
  localparam logic [3:0] ST_WAIT = 4'd10;
  localparam logic [3:0] ST_EMIT = 4'd11;
  localparam logic [3:0] ST_EDON = 4'd12;

  logic signed [C-1:0] edge_ax, edge_ay, edge_bx, edge_by;
  logic signed [C-1:0] cur_x, cur_y, first_x, first_y, prev_x, prev_y;
  logic signed [C-1:0] sx, sy, ex, ey;
  logic                cur_last, have_first, closing, which, axis;
  logic [7:0]          emitted_count;
  logic [3:0]          state;
  logic [1:0]          post;

  logic signed [PW-1:0] p1, p2;
  logic signed [XW-1:0] cs, ce;
  logic signed [XW:0]   dd;
  logic [XW-1:0]        pm, den;
  logic [RW-1:0]        r;
  logic [DW-1:0]        mag, q;
  logic                 dneg, nodiv;
  logic [IW-1:0]        bit_i;
  logic signed [C-1:0]  base_a;

  // shared multiplier operands
  logic signed [C-1:0]  ptx, pty;
  logic signed [DW-1:0] m_a, m_b;
  logic signed [PW-1:0] prod;
  logic signed [XW-1:0] cross_val;
  logic signed [DW-1:0] dsel;
  logic signed [C+1:0]  base, base_adj;

  always_comb begin
    ptx = which ? ex : sx;
    pty = which ? ey : sy;
    if (state == ST_M1) begin
      m_a = {edge_bx[C-1], edge_bx} - {edge_ax[C-1], edge_ax};
      m_b = {pty[C-1], pty} - {edge_ay[C-1], edge_ay};
    end else begin
      m_a = {edge_by[C-1], edge_by} - {edge_ay[C-1], edge_ay};
      m_b = {ptx[C-1], ptx} - {edge_ax[C-1], edge_ax};
    end
    prod = m_a * m_b;
    cross_val = {p1[PW-1], p1} - {p2[PW-1], p2};
    dsel = axis ? ({ey[C-1], ey} - {sy[C-1], sy}) : ({ex[C-1], ex} - {sx[C-1], sx});
  end

  // truncate toward zero: pull a rounded-down magnitude back by one
  always_comb begin
    if (nodiv) begin
      base = {base_a[C-1], base_a[C-1], base_a};
    end else if (dneg) begin
      base = {base_a[C-1], base_a[C-1], base_a} - {1'b0, q};
    end else begin
      base = {base_a[C-1], base_a[C-1], base_a} + {1'b0, q};
    end
    base_adj = base;
    if (!nodiv && r != '0) begin
      if (!dneg && base[C+1]) begin
        base_adj = base + (C+2)'(1);
      end else if (dneg && !base[C+1] && base != '0) begin
        base_adj = base - (C+2)'(1);
      end
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_ax <= '0;
      edge_ay <= '0;
      edge_bx <= '0;
      edge_by <= '0;
    end else if (write_enable) begin
      case (write_index)
        IDX_AX: edge_ax <= write_data;
        IDX_AY: edge_ay <= write_data;
        IDX_BX: edge_bx <= write_data;
        IDX_BY: edge_by <= write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      have_first    <= 1'b0;
      emitted_count <= '0;
      closing       <= 1'b0;
      which         <= 1'b0;
      axis          <= 1'b0;
      post          <= pec_pkg::POST_IDLE;
      first_x       <= '0;
      first_y       <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_x    <= vertex_x;
            cur_y    <= vertex_y;
            cur_last <= last_vertex;
            which    <= 1'b0;
            ex       <= vertex_x;
            ey       <= vertex_y;
            if (have_first) begin
              closing <= 1'b0;
              sx      <= prev_x;
              sy      <= prev_y;
              state   <= ST_M1;
            end else begin
              have_first <= 1'b1;
              first_x    <= vertex_x;
              first_y    <= vertex_y;
              prev_x     <= vertex_x;
              prev_y     <= vertex_y;
              // lone vertex polygon closes onto itself
              if (last_vertex) begin
                closing <= 1'b1;
                sx      <= vertex_x;
                sy      <= vertex_y;
                state   <= ST_M1;
              end
            end
          end
        end
        ST_M1: begin
          p1    <= prod;
          state <= ST_M2;
        end
        ST_M2: begin
          p2    <= prod;
          state <= ST_CR;
        end
        ST_CR: begin
          if (which) begin
            ce    <= cross_val;
            state <= ST_DEC;
          end else begin
            cs    <= cross_val;
            which <= 1'b1;
            state <= ST_M1;
          end
        end
        ST_DEC: begin
          pm    <= cs[XW-1] ? XW'(-cs) : cs;
          dd    <= {ce[XW-1], ce} - {cs[XW-1], cs};
          state <= ST_DEN;
        end
        ST_DEN: begin
          den  <= dd[XW] ? XW'(-dd) : dd[XW-1:0];
          axis <= 1'b0;
          if (cs[XW-1] != ce[XW-1]) begin
            state <= ST_DIV0;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_DIV0: begin
          dneg   <= dsel[DW-1];
          mag    <= dsel[DW-1] ? DW'(-dsel) : dsel;
          base_a <= axis ? sy : sx;
          nodiv  <= (den == '0) || (pm > den);
          r      <= '0;
          q      <= '0;
          bit_i  <= IW'(C);
          if ((den == '0) || (pm > den)) begin
            state <= ST_DFIN;
          end else begin
            state <= ST_DADD;
          end
        end
        ST_DADD: begin
          r     <= {r[RW-2:0], 1'b0} + (mag[bit_i] ? {2'b00, pm} : '0);
          q     <= {q[DW-2:0], 1'b0};
          state <= ST_DSUB;
        end
        ST_DSUB: begin
          if (r >= {2'b00, den}) begin
            r <= r - {2'b00, den};
            q <= q + DW'(1);
          end else if (bit_i == '0) begin
            state <= ST_DFIN;
          end else begin
            bit_i <= bit_i - IW'(1);
            state <= ST_DADD;
          end
        end
        ST_DFIN: begin
          if (axis) begin
            out_y <= base_adj[C-1:0];
            post  <= pec_pkg::POST_E;
            if (emitted_count < CAP) emitted_count <= emitted_count + 8'd1;
            out_x          <= out_x;
            is_vertex      <= 1'b1;
            end_of_polygon <= 1'b0;
            vertex_count   <= '0;
            state          <= ST_WAIT;
          end else begin
            // x is parked in the output register until y is ready
            out_x <= base_adj[C-1:0];
            axis  <= 1'b1;
            state <= ST_DIV0;
          end
        end
        ST_WAIT: begin
          if (out_ready) begin
            case (post)
              pec_pkg::POST_E:    state <= ST_EMIT;
              pec_pkg::POST_DONE: state <= ST_EDON;
              pec_pkg::POST_IDLE: state <= ST_IDLE;
              default:            state <= ST_DIV0;
            endcase
          end
        end
        ST_EMIT: begin
          if (!ce[XW-1]) begin
            state <= ST_EDON;
          end else begin
            out_x          <= ex;
            out_y          <= ey;
            is_vertex      <= 1'b1;
            end_of_polygon <= 1'b0;
            vertex_count   <= '0;
            post           <= pec_pkg::POST_DONE;
            if (emitted_count < CAP) emitted_count <= emitted_count + 8'd1;
            state          <= ST_WAIT;
          end
        end
        ST_EDON: begin
          if (!closing) begin
            prev_x <= cur_x;
            prev_y <= cur_y;
            if (cur_last) begin
              closing <= 1'b1;
              which   <= 1'b0;
              sx      <= cur_x;
              sy      <= cur_y;
              ex      <= first_x;
              ey      <= first_y;
              state   <= ST_M1;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            out_x          <= '0;
            out_y          <= '0;
            is_vertex      <= 1'b0;
            end_of_polygon <= 1'b1;
            vertex_count   <= emitted_count;
            emitted_count  <= '0;
            have_first     <= 1'b0;
            post           <= pec_pkg::POST_IDLE;
            state          <= ST_WAIT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
